>>> design/qlte_pkg.sv
// Package for the Q-learning table engine: operation codes, register indexes,
// fixed field widths and the shared fraction clamp helper. No dependencies.
`default_nettype none
package qlte_pkg;
	localparam int FRAC_W = 17;
	localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [2:0] OP_UPDATE = 3'd0;
	localparam logic [2:0] OP_CHOOSE = 3'd1;
	localparam logic [2:0] OP_DECAY  = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_WRITE  = 3'd4;

	localparam logic [2:0] REG_LEARN_RATE = 3'd0;
	localparam logic [2:0] REG_DISCOUNT   = 3'd1;
	localparam logic [2:0] REG_STATES     = 3'd2;
	localparam logic [2:0] REG_ACTIONS    = 3'd3;
	localparam logic [2:0] REG_EXP_INIT   = 3'd4;
	localparam logic [2:0] REG_EXP_FINAL  = 3'd5;
	localparam logic [2:0] REG_EXP_DECAY  = 3'd6;

	localparam int DEF_MAX_STATES  = 128;
	localparam int DEF_MAX_ACTIONS = 8;
	localparam int DEF_Q_WIDTH     = 32;

	// Shared arithmetic unit command.
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [17:0] b;
	} qlte_mul_cmd_t;

	function automatic logic [16:0] clamp_frac(input logic [16:0] f);
		clamp_frac = (f > ONE_Q16) ? ONE_Q16 : f;
	endfunction
endpackage
`default_nettype wire

>>> design/qlte_mul.sv
// Shared signed multiplier of the engine: a signed value times an unsigned
// Q1.16 fraction, floor-shifted by 16, registered. Uses qlte_pkg.
`default_nettype none
module qlte_mul (
	input  wire logic                   clk,
	input  wire qlte_pkg::qlte_mul_cmd_t cmd,
	output logic signed [63:0]          prod_q
);
	import qlte_pkg::*;
	logic signed [81:0] full;
	// Operands are held stable by the sequencer; value is at most 49 bits.
	assign full = $signed(cmd.a) * $signed({1'b0, cmd.b[16:0]});
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			prod_q <= full[79:16];
		end
	end
endmodule
`default_nettype wire

>>> design/q_learning_table_engine.sv
// Top level of the Q-learning table engine: sequencer, Q table memory and
// configuration registers. Depends on qlte_pkg and qlte_mul.
`default_nettype none
// The engine holds a Q table of MAX_STATES x MAX_ACTIONS signed Q16.16
// entries in one single-port memory and runs one operation per input word.
// After reset a clearing pass writes zero to every entry (1024 by default),
// one entry per cycle; no input word is taken meanwhile, configuration
// writes are. Each operation then walks a small sequencer that reads table
// entries one at a time through the memory port. The row scan visits each
// entry of the row in turn (ST_SCAN, then ST_SCANW), and the choose reduces
// random_pick modulo actions_in_use with a restoring remainder. All
// multiplies by a fraction go through the one shared multiplier. The result
// word sits in an output register, and in_stall is high while an operation
// is in flight or the result waits, so the next word is taken in the cycle
// after the result is accepted at the earliest.
module q_learning_table_engine #(
	parameter int MAX_STATES  = qlte_pkg::DEF_MAX_STATES,
	parameter int MAX_ACTIONS = qlte_pkg::DEF_MAX_ACTIONS,
	parameter int Q_WIDTH     = qlte_pkg::DEF_Q_WIDTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         action,
	input  wire logic [6:0]         cur_state,
	input  wire logic [2:0]         taken_action,
	input  wire logic signed [15:0] reward,
	input  wire logic [6:0]         next_state,
	input  wire logic [15:0]        random_draw,
	input  wire logic [15:0]        random_pick,
	input  wire logic signed [31:0] write_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      result_value,
	output logic [2:0]              chosen_action,
	output logic                    explored,
	output logic [16:0]             epsilon_now,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [16:0]        cfg_data
);
	import qlte_pkg::*;

	localparam int SW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int AW    = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
	localparam int DEPTH = MAX_STATES * MAX_ACTIONS;
	localparam int ADW   = SW + AW;
	localparam logic signed [63:0] QMAX = 64'sd2 ** (Q_WIDTH - 1) - 64'sd1;
	localparam logic signed [63:0] QMIN = -QMAX - 64'sd1;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_SCAN   = 4'd2;
	localparam logic [3:0] ST_SCANW  = 4'd3;
	localparam logic [3:0] ST_MUL1   = 4'd4;
	localparam logic [3:0] ST_TD     = 4'd5;
	localparam logic [3:0] ST_MUL2   = 4'd6;
	localparam logic [3:0] ST_WB     = 4'd7;
	localparam logic [3:0] ST_RDW    = 4'd8;
	localparam logic [3:0] ST_RDD    = 4'd9;
	localparam logic [3:0] ST_DEC1   = 4'd10;
	localparam logic [3:0] ST_DEC2   = 4'd11;
	localparam logic [3:0] ST_DEC3   = 4'd12;
	localparam logic [3:0] ST_OUT    = 4'd13;
	localparam logic [3:0] ST_PICK   = 4'd14;

	logic [3:0] state_q;

	// Configuration registers.
	logic [16:0] lr_q, disc_q, ini_q, fin_q, dec_q;
	logic [7:0]  nst_q;
	logic [3:0]  nact_q;
	logic [16:0] eps_q, norm_q;

	// Clamped counts, widened to compare with any parameter.
	logic [12:0] ns_c;
	logic [6:0]  na_c;
	always_comb begin
		ns_c = (nst_q == 8'd0) ? 13'd1 : 13'(nst_q);
		if (ns_c > 13'(MAX_STATES)) ns_c = 13'(MAX_STATES);
		na_c = (nact_q == 4'd0) ? 7'd1 : 7'(nact_q);
		if (na_c > 7'(MAX_ACTIONS)) na_c = 7'(MAX_ACTIONS);
	end

	// Table memory.
	logic signed [Q_WIDTH-1:0] mem [DEPTH];
	logic signed [Q_WIDTH-1:0] rd_q;
	logic [ADW-1:0] addr;
	logic signed [Q_WIDTH-1:0] wdata;
	logic we;
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rd_q <= mem[addr];
	end

	// Latched item.
	logic [2:0]  op_q;
	logic [12:0] s_q, sn_q;
	logic [6:0]  a_q;
	logic signed [15:0] r_q;
	logic [15:0] draw_q, pick_q;
	logic signed [31:0] wv_q;
	logic [ADW:0] clr_q;
	logic [6:0]  scan_q;
	logic [6:0]  ba_q;
	logic signed [Q_WIDTH-1:0] best_q, cur_q;
	logic signed [63:0] td_q;
	logic [15:0] pickrem_q;
	logic [3:0]  pcnt_q;
	logic [7:0]  prem_q;

	// One step of the restoring remainder of random_pick by actions_in_use.
	logic [7:0] prem_c;
	always_comb begin
		prem_c = {prem_q[6:0], pickrem_q[15]};
		if (prem_c >= 8'(na_c)) prem_c = prem_c - 8'(na_c);
	end

	// Shared multiplier.
	qlte_mul_cmd_t mcmd;
	logic signed [63:0] prod;
	qlte_mul u_mul (.clk(clk), .cmd(mcmd), .prod_q(prod));

	always_comb begin
		mcmd = '0;
		unique case (state_q)
			ST_MUL1: begin
				mcmd.start = 1'b1;
				mcmd.a = 64'(best_q);
				mcmd.b = {1'b0, clamp_frac(disc_q)};
			end
			ST_MUL2: begin
				mcmd.start = 1'b1;
				mcmd.a = td_q;
				mcmd.b = {1'b0, clamp_frac(lr_q)};
			end
			ST_DEC1: begin
				mcmd.start = 1'b1;
				mcmd.a = 64'(norm_q);
				mcmd.b = {1'b0, clamp_frac(dec_q)};
			end
			ST_DEC3: begin
				// norm_q already holds the decayed value here.
				mcmd.start = 1'b1;
				mcmd.a = 64'(clamp_frac(ini_q)) - 64'(clamp_frac(fin_q));
				mcmd.b = {1'b0, norm_q};
			end
			default: ;
		endcase
	end

	function automatic logic signed [63:0] satq(input logic signed [63:0] v);
		satq = (v > QMAX) ? QMAX : ((v < QMIN) ? QMIN : v);
	endfunction

	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || out_valid;
	assign cfg_ready = 1'b1;

	logic signed [63:0] td_c, nv_c, eps_c;
	logic [ADW-1:0] a_s, a_sn;
	always_comb begin
		a_s  = ADW'(s_q) * ADW'(MAX_ACTIONS) + ADW'(a_q);
		a_sn = ADW'(sn_q) * ADW'(MAX_ACTIONS) + ADW'(scan_q);
		td_c = satq(64'(r_q) * 64'sd65536 + prod - 64'(cur_q));
		nv_c = satq(64'(cur_q) + prod);
		eps_c = 64'(clamp_frac(fin_q)) + prod;
		if (eps_c < 0) eps_c = 0;
		else if (eps_c > 64'sd65536) eps_c = 64'sd65536;
		we = 1'b0;
		wdata = '0;
		addr = a_s;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				addr = clr_q[ADW-1:0];
			end
			ST_SCAN: addr = a_sn;
			ST_WB: begin
				we = 1'b1;
				wdata = Q_WIDTH'(nv_c);
			end
			ST_RDW: begin
				we = (op_q == OP_WRITE);
				wdata = Q_WIDTH'(satq(64'(wv_q)));
			end
			default: ;
		endcase
	end

	logic signed [63:0] res64;
	always_comb begin
		res64 = (td_q < 0) ? -td_q : td_q;
		if (res64 > 64'sd2147483647) res64 = 64'sd2147483647;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
			lr_q <= 17'd6554; disc_q <= 17'd58982; nst_q <= 8'd128;
			nact_q <= 4'd8; ini_q <= 17'd58982; fin_q <= 17'd655;
			dec_q <= 17'd62259; eps_q <= 17'd58982; norm_q <= ONE_Q16;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_LEARN_RATE: lr_q <= cfg_data;
					REG_DISCOUNT:   disc_q <= cfg_data;
					REG_STATES:     nst_q <= cfg_data[7:0];
					REG_ACTIONS:    nact_q <= cfg_data[3:0];
					REG_EXP_INIT:   ini_q <= cfg_data;
					REG_EXP_FINAL:  fin_q <= cfg_data;
					REG_EXP_DECAY:  dec_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (ADW+1)'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (accept) begin
					op_q <= action; s_q <= 13'(cur_state); sn_q <= 13'(next_state);
					a_q <= 7'(taken_action); r_q <= reward; draw_q <= random_draw;
					pick_q <= random_pick; wv_q <= write_value;
					result_value <= '0; chosen_action <= '0; explored <= 1'b0;
					td_q <= '0; scan_q <= '0; ba_q <= '0;
					if (action == OP_UPDATE) begin
						if (13'(cur_state) < ns_c && 7'(taken_action) < na_c &&
						    13'(next_state) < ns_c) state_q <= ST_SCAN;
						else state_q <= ST_OUT;
					end else if (action == OP_CHOOSE) begin
						sn_q <= 13'(cur_state);
						state_q <= (13'(cur_state) < ns_c) ? ST_SCAN : ST_OUT;
					end else if (action == OP_DECAY) begin
						state_q <= ST_DEC1;
					end else if (action == OP_READ || action == OP_WRITE) begin
						state_q <= (13'(cur_state) < ns_c && 7'(taken_action) < na_c)
						           ? ST_RDW : ST_OUT;
					end else state_q <= ST_OUT;
				end
				ST_SCAN: state_q <= ST_SCANW;
				ST_SCANW: begin
					// rd_q holds the entry at scan_q.
					if (scan_q == 7'd0 || rd_q > best_q) begin
						best_q <= rd_q;
						ba_q <= scan_q;
					end
					if (scan_q + 7'd1 < na_c) begin
						scan_q <= scan_q + 7'd1;
						state_q <= ST_SCAN;
					end else if (op_q == OP_UPDATE) begin
						state_q <= ST_MUL1;
					end else begin
						pickrem_q <= pick_q;
						prem_q <= '0;
						pcnt_q <= '0;
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					// Restoring remainder, one bit of the quotient a cycle.
					pickrem_q <= {pickrem_q[14:0], 1'b0};
					prem_q <= prem_c;
					pcnt_q <= pcnt_q + 1'b1;
					if (pcnt_q == 4'd15) begin
						if (16'(draw_q) < 16'(eps_q) || eps_q[16]) begin
							chosen_action <= 3'(prem_c);
							explored <= 1'b1;
						end else chosen_action <= 3'(ba_q);
						state_q <= ST_OUT;
					end
				end
				ST_MUL1: state_q <= ST_RDW;
				ST_RDW: state_q <= (op_q == OP_WRITE) ? ST_OUT : ST_RDD;
				ST_RDD: begin
					cur_q <= rd_q;
					if (op_q == OP_READ) begin
						result_value <= 32'(satq(64'(rd_q)) > 64'sd2147483647 ?
						  64'sd2147483647 : (satq(64'(rd_q)) < -64'sd2147483648 ?
						  -64'sd2147483648 : 64'(rd_q)));
						state_q <= ST_OUT;
					end else state_q <= ST_TD;
				end
				ST_TD: begin
					td_q <= td_c;
					state_q <= ST_MUL2;
				end
				ST_MUL2: state_q <= ST_WB;
				ST_WB: begin
					result_value <= 32'(res64);
					state_q <= ST_OUT;
				end
				ST_DEC1: state_q <= ST_DEC2;
				ST_DEC2: begin
					norm_q <= 17'(prod);
					state_q <= ST_DEC3;
				end
				ST_DEC3: state_q <= ST_OUT;
				ST_OUT: begin
					if (op_q == OP_DECAY) eps_q <= 17'(eps_c);
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign epsilon_now = eps_q;

	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	ap_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_OUT) else $error("stray result");
	ap_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !we) else $error("table write while idle");
endmodule
`default_nettype wire

>>> tb/q_learning_table_engine_tb.sv
// Self-checking testbench for the Q-learning table engine: a directed table
// followed by random words, checked against listed results or an in-bench predictor.
// Depends on qlte_pkg and the q_learning_table_engine RTL only.
`timescale 1ns / 100ps
module q_learning_table_engine_tb;
	import qlte_pkg::*;

	localparam int  ROW_LEN      = DEF_MAX_ACTIONS;
	localparam int  TABLE_DEPTH  = DEF_MAX_STATES * DEF_MAX_ACTIONS;
	localparam int  RANDOM_WORDS = 1230;
	localparam int  DRAIN_CYCLES = 40;
	localparam int  LONG_HOLD    = 200;
	localparam int  CYCLE_LIMIT  = 600000;
	localparam longint QMAX      = 64'sd2147483647;
	localparam longint QMIN      = -64'sd2147483648;

	// Operation codes the block does not define; they must leave state alone.
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct {
		logic [2:0]         op;
		logic [6:0]         s;
		logic [2:0]         a;
		logic signed [15:0] r;
		logic [6:0]         sn;
		logic [15:0]        draw;
		logic [15:0]        pick;
		logic signed [31:0] wv;
	} q_word_t;

	typedef struct {
		logic signed [31:0] value;
		logic [2:0]         chosen;
		logic               expl;
		logic [16:0]        eps;
	} q_result_t;

	typedef struct {
		q_word_t   w;
		bit        typed;
		q_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] action = '0;
	logic [6:0] cur_state = '0;
	logic [2:0] taken_action = '0;
	logic signed [15:0] reward = '0;
	logic [6:0] next_state = '0;
	logic [15:0] random_draw = '0;
	logic [15:0] random_pick = '0;
	logic signed [31:0] write_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] result_value;
	logic [2:0] chosen_action;
	logic explored;
	logic [16:0] epsilon_now;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [16:0] cfg_data = '0;

	q_learning_table_engine uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .cur_state(cur_state), .taken_action(taken_action),
		.reward(reward), .next_state(next_state), .random_draw(random_draw),
		.random_pick(random_pick), .write_value(write_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .chosen_action(chosen_action),
		.explored(explored), .epsilon_now(epsilon_now),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// 12 ns clock period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// Shadow copy of the engine: table, exploration state and registers.
	longint       shadow_q [TABLE_DEPTH];
	logic [16:0]  shadow_eps;
	logic [16:0]  shadow_norm;
	logic [16:0]  alpha_r, gamma_r, eps_init_r, eps_final_r, eps_decay_r;
	logic [7:0]   states_r;
	logic [3:0]   actions_r;

	q_result_t pending_results[$];
	int        error_count = 0;
	int        cycle_count = 0;
	bit        hold_request = 0;

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint frac_of(logic [16:0] f);
		return (f > ONE_Q16) ? longint'(ONE_Q16) : longint'(f);
	endfunction

	function automatic int states_used();
		return states_r < 1 ? 1 : (states_r > DEF_MAX_STATES ? DEF_MAX_STATES : states_r);
	endfunction

	function automatic int actions_used();
		return actions_r < 1 ? 1 : (actions_r > DEF_MAX_ACTIONS ? DEF_MAX_ACTIONS : actions_r);
	endfunction

	// First action with the highest value in a row; the value comes back too.
	function automatic int best_action(int row, output longint best);
		int ba;
		ba = 0;
		best = shadow_q[row * ROW_LEN];
		for (int k = 1; k < actions_used(); k++) begin
			if (shadow_q[row * ROW_LEN + k] > best) begin
				best = shadow_q[row * ROW_LEN + k];
				ba = k;
			end
		end
		return ba;
	endfunction

	// Advances the shadow state by one accepted word and returns its result.
	function automatic q_result_t apply_q_word(q_word_t w);
		q_result_t o;
		longint m, td, ini, fin, res;
		int ns, na, idx;
		bit s_ok, a_ok;
		ns = states_used();
		na = actions_used();
		s_ok = w.s < ns;
		a_ok = w.a < na;
		idx = w.s * ROW_LEN + w.a;
		res = 0;
		o.chosen = '0;
		o.expl = 1'b0;
		case (w.op)
			OP_UPDATE: begin
				if (s_ok && a_ok && w.sn < ns) begin
					void'(best_action(w.sn, m));
					td = longint'(w.r) * 65536 + ((frac_of(gamma_r) * m) >>> 16)
						- shadow_q[idx];
					td = clip(td, QMIN, QMAX);
					shadow_q[idx] = clip(shadow_q[idx] + ((frac_of(alpha_r) * td) >>> 16),
						QMIN, QMAX);
					res = td < 0 ? -td : td;
				end
			end
			OP_CHOOSE: begin
				if (s_ok) begin
					o.chosen = 3'(best_action(w.s, m));
					if (w.draw < shadow_eps) begin
						o.chosen = 3'(w.pick % na);
						o.expl = 1'b1;
					end
				end
			end
			OP_DECAY: begin
				ini = frac_of(eps_init_r);
				fin = frac_of(eps_final_r);
				shadow_norm = 17'((frac_of(eps_decay_r) * longint'(shadow_norm)) >> 16);
				shadow_eps = 17'(clip(fin + ((longint'(shadow_norm) * (ini - fin)) >>> 16),
					0, 65536));
			end
			OP_READ: begin
				if (s_ok && a_ok)
					res = shadow_q[idx];
			end
			OP_WRITE: begin
				if (s_ok && a_ok)
					shadow_q[idx] = longint'(w.wv);
			end
			default: ;
		endcase
		o.value = 32'(clip(res, QMIN, QMAX));
		o.eps = shadow_eps;
		return o;
	endfunction

	// Offers one word after a random idle gap and records its expectation at
	// the edge where it is taken. Called at a rising edge, returns at one.
	task automatic send_word(q_word_t w, bit typed, q_result_t typed_res);
		int gap;
		q_result_t predicted;
		gap = $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= w.op;
		cur_state <= w.s;
		taken_action <= w.a;
		reward <= w.r;
		next_state <= w.sn;
		random_draw <= w.draw;
		random_pick <= w.pick;
		write_value <= w.wv;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && !in_stall));
		predicted = apply_q_word(w);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	// Writes one register and then leaves the channel idle.
	task automatic write_register(logic [2:0] idx, logic [16:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LEARN_RATE: alpha_r = value;
			REG_DISCOUNT:   gamma_r = value;
			REG_STATES:     states_r = value[7:0];
			REG_ACTIONS:    actions_r = value[3:0];
			REG_EXP_INIT:   eps_init_r = value;
			REG_EXP_FINAL:  eps_final_r = value;
			REG_EXP_DECAY:  eps_decay_r = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Waits until every result is back and the sequencer has surely settled.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [16:0] pick_fraction();
		case ($urandom_range(0, 5))
			0: return 17'd0;
			1: return ONE_Q16;
			2: return 17'h1FFFF;
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	// Random register setting; most phases keep the table large so that
	// updates and choices reach real rows, a few shrink it to the edges.
	task automatic program_random_setting();
		logic [16:0] st, ac;
		case ($urandom_range(0, 7))
			0: st = 17'd0;
			1: st = 17'd1;
			2: st = 17'd255;
			3: st = 17'($urandom_range(2, 16));
			default: st = 17'd128;
		endcase
		case ($urandom_range(0, 6))
			0: ac = 17'd0;
			1: ac = 17'd1;
			2: ac = 17'd15;
			3: ac = 17'($urandom_range(2, 7));
			default: ac = 17'd8;
		endcase
		write_register(REG_LEARN_RATE, pick_fraction());
		write_register(REG_DISCOUNT, pick_fraction());
		write_register(REG_STATES, st);
		write_register(REG_ACTIONS, ac);
		write_register(REG_EXP_INIT, pick_fraction());
		write_register(REG_EXP_FINAL, pick_fraction());
		write_register(REG_EXP_DECAY, pick_fraction());
	endtask

	function automatic q_word_t random_word();
		q_word_t w;
		int pct;
		pct = $urandom_range(0, 99);
		if (pct < 35) w.op = OP_UPDATE;
		else if (pct < 55) w.op = OP_CHOOSE;
		else if (pct < 62) w.op = OP_DECAY;
		else if (pct < 80) w.op = OP_READ;
		else if (pct < 96) w.op = OP_WRITE;
		else w.op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
		// Mostly indices inside the table in use, sometimes anywhere.
		if ($urandom_range(0, 9) < 8) begin
			w.s = 7'($urandom_range(0, states_used() - 1));
			w.sn = 7'($urandom_range(0, states_used() - 1));
			w.a = 3'($urandom_range(0, actions_used() - 1));
		end else begin
			w.s = 7'($urandom);
			w.sn = 7'($urandom);
			w.a = 3'($urandom);
		end
		w.r = 16'($urandom);
		if ($urandom_range(0, 3) == 0) w.r = 16'($signed($urandom_range(0, 8)) - 4);
		w.draw = 16'($urandom);
		w.pick = 16'($urandom);
		case ($urandom_range(0, 7))
			0: w.wv = 32'h7FFFFFFF;
			1: w.wv = 32'h80000000;
			2: w.wv = 32'($signed($urandom_range(0, 2000000)) - 1000000);
			default: w.wv = 32'($urandom);
		endcase
		return w;
	endfunction

	function automatic stim_row_t row(logic [2:0] op, int s, int a, int r, int sn,
		int draw, int pick, logic [31:0] wv, bit typed,
		logic [31:0] value, int chosen, bit expl, int eps);
		stim_row_t t;
		t.w.op = op; t.w.s = 7'(s); t.w.a = 3'(a); t.w.r = 16'(r); t.w.sn = 7'(sn);
		t.w.draw = 16'(draw); t.w.pick = 16'(pick); t.w.wv = wv;
		t.typed = typed;
		t.res.value = value; t.res.chosen = 3'(chosen); t.res.expl = expl;
		t.res.eps = 17'(eps);
		return t;
	endfunction

	// Receiving side: random stall before each word, and one long hold-off
	// on request so that the engine backs up and stalls its input.
	initial begin : result_checker
		int w;
		q_result_t exp_r;
		@(posedge clk);
		forever begin
			w = $urandom_range(0, 8);
			if (hold_request) begin
				w = LONG_HOLD;
				hold_request = 0;
			end
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word value=%0d", $time, result_value);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result_value !== exp_r.value) begin
					$display("%0t: result_value expected %0d actual %0d",
						$time, exp_r.value, result_value);
					error_count++;
				end
				if (chosen_action !== exp_r.chosen) begin
					$display("%0t: chosen_action expected %0d actual %0d",
						$time, exp_r.chosen, chosen_action);
					error_count++;
				end
				if (explored !== exp_r.expl) begin
					$display("%0t: explored expected %0d actual %0d",
						$time, exp_r.expl, explored);
					error_count++;
				end
				if (epsilon_now !== exp_r.eps) begin
					$display("%0t: epsilon_now expected %0d actual %0d",
						$time, exp_r.eps, epsilon_now);
					error_count++;
				end
			end
		end
	end

	// Watchdog: the clearing pass plus every word at its slowest fits many
	// times over inside this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t directed[$];
		q_result_t none;
		none = '{default: '0};
		foreach (shadow_q[i]) shadow_q[i] = 0;
		shadow_eps = 17'd58982;
		shadow_norm = ONE_Q16;
		alpha_r = 17'd6554;
		gamma_r = 17'd58982;
		states_r = 8'd128;
		actions_r = 4'd8;
		eps_init_r = 17'd58982;
		eps_final_r = 17'd655;
		eps_decay_r = 17'd62259;

		// Reset defaults first, then the field extremes, every operation,
		// saturation on both sides, exploration, and the unused codes.
		directed.push_back(row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 58982));
		directed.push_back(row(OP_WRITE, 5, 3, 0, 0, 0, 0, 32'h7FFFFFFF, 1, 0, 0, 0, 58982));
		directed.push_back(row(OP_READ, 5, 3, 0, 0, 0, 0, 0, 1, 32'h7FFFFFFF, 0, 0, 58982));
		directed.push_back(row(OP_WRITE, 5, 2, 0, 0, 0, 0, 32'h80000000, 1, 0, 0, 0, 58982));
		directed.push_back(row(OP_READ, 5, 2, 0, 0, 0, 0, 0, 1, 32'h80000000, 0, 0, 58982));
		directed.push_back(row(OP_UPDATE, 5, 3, 32767, 5, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_UPDATE, 5, 2, -32768, 5, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_READ, 5, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_UPDATE, 127, 7, -1, 127, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_CHOOSE, 5, 0, 0, 0, 65535, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_CHOOSE, 5, 0, 0, 0, 0, 65535, 0, 1, 0, 7, 1, 58982));
		directed.push_back(row(OP_CHOOSE, 0, 0, 0, 0, 65535, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_DECAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_DECAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_READ, 127, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_SPARE_5, 5, 3, 1, 5, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_SPARE_6, 5, 3, 1, 5, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_SPARE_7, 127, 7, -1, 127, 65535, 65535, 32'hFFFFFFFF,
			0, 0, 0, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_word(directed[i].w, directed[i].typed, directed[i].res);

		// A one-state, one-action table: anything past entry zero is ignored.
		wait_idle();
		write_register(REG_STATES, 17'd1);
		write_register(REG_ACTIONS, 17'd1);
		send_word(row(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0).w, 0, none);
		send_word(row(OP_WRITE, 0, 1, 0, 0, 0, 0, 32'h1234, 0, 0, 0, 0, 0).w, 0, none);
		send_word(row(OP_UPDATE, 0, 0, 100, 1, 0, 0, 0, 0, 0, 0, 0, 0).w, 0, none);
		send_word(row(OP_CHOOSE, 0, 0, 0, 0, 0, 65535, 0, 0, 0, 0, 0, 0).w, 0, none);
		wait_idle();
		write_register(REG_STATES, 17'd128);
		write_register(REG_ACTIONS, 17'd8);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 120 == 60) begin
				wait_idle();
				program_random_setting();
			end
			// Long receiver hold while words keep coming.
			if (n == 200 || n == 800) hold_request = 1;
			// Sender waits out every outstanding result once, before word 400.
			if (n == 400) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			send_word(random_word(), 0, none);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

>>> filelist.f
design/qlte_pkg.sv
design/qlte_mul.sv
design/q_learning_table_engine.sv
tb/q_learning_table_engine_tb.sv
